// ===== rtl/sndc_pkg.sv =====
// shared constants and types for the strided copy address generator
package sndc_pkg;

  localparam int FUNC_W     = 2;
  localparam int AXIS_W     = 2;
  localparam int EXT_W      = 32;
  localparam int STRIDE_W   = 32;
  localparam int OUT_ADDR_W = 48;
  localparam int ESIZE_W    = 9;
  localparam int RANK_W     = 3;
  localparam int OFF_W      = 32;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_START = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_STEP  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_ELEM      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_ARMED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ELEM_SIZE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANK       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_BASE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_BASE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_OFFSET = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DST_OFFSET = 3'd5;

  localparam logic [ESIZE_W-1:0] ELEM_SIZE_RST = 9'd1;
  localparam logic [RANK_W-1:0]  RANK_RST      = 3'd1;

  typedef struct packed {
    logic wrap;
    logic empty;
  } cell_stat_t;

  typedef struct packed {
    logic              vld;
    logic [AXIS_W-1:0] axis;
  } ld_ctl_t;

endpackage

// ===== rtl/sndc_if.sv =====
// item channel interfaces for the strided copy address generator
interface sndc_in_if import sndc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [FUNC_W-1:0]          func;
  logic [AXIS_W-1:0]          axis;
  logic [EXT_W-1:0]           extent;
  logic signed [STRIDE_W-1:0] src_stride;
  logic signed [STRIDE_W-1:0] dst_stride;

  modport source (output valid, func, axis, extent, src_stride, dst_stride, input ready);
  modport sink (input valid, func, axis, extent, src_stride, dst_stride, output ready);
endinterface

interface sndc_out_if import sndc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [OUT_ADDR_W-1:0] src_addr;
  logic [OUT_ADDR_W-1:0] dst_addr;
  logic                  last;
  logic [STAT_W-1:0]     status;

  modport source (output valid, src_addr, dst_addr, last, status, input ready);
  modport sink (input valid, src_addr, dst_addr, last, status, output ready);
endinterface

// ===== rtl/sndc_scale.sv =====
// two stage multiplier that scales an axis descriptor to byte strides and rewind steps
module sndc_scale import sndc_pkg::*; #(
  parameter int AW = 48
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       go_i,
  input  logic [AXIS_W-1:0]          axis_i,
  input  logic [EXT_W-1:0]           extent_i,
  input  logic signed [STRIDE_W-1:0] src_stride_i,
  input  logic signed [STRIDE_W-1:0] dst_stride_i,
  input  logic [ESIZE_W-1:0]         elem_size_i,
  output ld_ctl_t                    ctl_o,
  output logic                       busy_o,
  output logic [EXT_W-1:0]           extent_o,
  output logic [AW-1:0]              src_stride_o,
  output logic [AW-1:0]              dst_stride_o,
  output logic [AW-1:0]              src_wrap_o,
  output logic [AW-1:0]              dst_wrap_o
);

  logic signed [ESIZE_W:0]             es_s;
  logic signed [EXT_W+1:0]             ext_s;
  logic signed [EXT_W+1:0]             one_m;
  logic signed [STRIDE_W+ESIZE_W:0]    src_ss_p, dst_ss_p;
  logic signed [STRIDE_W+EXT_W+1:0]    src_pw_p, dst_pw_p;
  logic [AW+ESIZE_W-1:0]               src_wp, dst_wp;

  logic                v1_q, v2_q;
  logic [AXIS_W-1:0]   axis1_q, axis2_q;
  logic [EXT_W-1:0]    ext1_q, ext2_q;
  logic [ESIZE_W-1:0]  es1_q;
  logic [AW-1:0]       src_ss1_q, dst_ss1_q, src_pw1_q, dst_pw1_q;
  logic [AW-1:0]       src_ss2_q, dst_ss2_q, src_w2_q, dst_w2_q;

  // stage one: stride times element size, stride times (1 - extent)
  assign es_s     = $signed({1'b0, elem_size_i});
  assign ext_s    = $signed({2'b00, extent_i});
  assign one_m    = (EXT_W+2)'(1) - ext_s;
  assign src_ss_p = src_stride_i * es_s;
  assign dst_ss_p = dst_stride_i * es_s;
  assign src_pw_p = src_stride_i * one_m;
  assign dst_pw_p = dst_stride_i * one_m;

  // stage two: scale the rewind step by element size
  assign src_wp = src_pw1_q * es1_q;
  assign dst_wp = dst_pw1_q * es1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= go_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      axis1_q   <= axis_i;
      ext1_q    <= extent_i;
      es1_q     <= elem_size_i;
      src_ss1_q <= AW'(src_ss_p);
      dst_ss1_q <= AW'(dst_ss_p);
      src_pw1_q <= AW'(src_pw_p);
      dst_pw1_q <= AW'(dst_pw_p);
    end
    if (v1_q) begin
      axis2_q   <= axis1_q;
      ext2_q    <= ext1_q;
      src_ss2_q <= src_ss1_q;
      dst_ss2_q <= dst_ss1_q;
      src_w2_q  <= src_wp[AW-1:0];
      dst_w2_q  <= dst_wp[AW-1:0];
    end
  end

  assign ctl_o.vld    = v2_q;
  assign ctl_o.axis   = axis2_q;
  assign busy_o       = v1_q | v2_q;
  assign extent_o     = ext2_q;
  assign src_stride_o = src_ss2_q;
  assign dst_stride_o = dst_ss2_q;
  assign src_wrap_o   = src_w2_q;
  assign dst_wrap_o   = dst_w2_q;

endmodule

// ===== rtl/sndc_cell.sv =====
// one axis cell: counter, descriptor and carry handed to the next outer axis
module sndc_cell import sndc_pkg::*; #(
  parameter int AW = 48
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clr_i,
  input  logic             ld_en_i,
  input  logic [EXT_W-1:0] ld_extent_i,
  input  logic [AW-1:0]    ld_src_stride_i,
  input  logic [AW-1:0]    ld_dst_stride_i,
  input  logic [AW-1:0]    ld_src_wrap_i,
  input  logic [AW-1:0]    ld_dst_wrap_i,
  input  logic             tok_i,
  output cell_stat_t       stat_o,
  output logic             carry_o,
  output logic [AW-1:0]    src_delta_o,
  output logic [AW-1:0]    dst_delta_o
);

  logic [EXT_W-1:0] cnt_q, cnt_inc, extent_q;
  logic             carry_q, wrap;
  logic [AW-1:0]    src_stride_q, dst_stride_q, src_wrap_q, dst_wrap_q;

  assign cnt_inc = cnt_q + EXT_W'(1);
  assign wrap    = (cnt_inc == extent_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      carry_q <= 1'b0;
    end else if (clr_i) begin
      cnt_q   <= '0;
      carry_q <= 1'b0;
    end else begin
      carry_q <= tok_i & wrap;
      if (tok_i) begin
        cnt_q <= wrap ? '0 : cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_en_i) begin
      extent_q     <= ld_extent_i;
      src_stride_q <= ld_src_stride_i;
      dst_stride_q <= ld_dst_stride_i;
      src_wrap_q   <= ld_src_wrap_i;
      dst_wrap_q   <= ld_dst_wrap_i;
    end
  end

  // rolled-over axis rewinds, otherwise one stride forward
  assign src_delta_o  = tok_i ? (wrap ? src_wrap_q : src_stride_q) : '0;
  assign dst_delta_o  = tok_i ? (wrap ? dst_wrap_q : dst_stride_q) : '0;
  assign stat_o.wrap  = wrap;
  assign stat_o.empty = (extent_q == '0);
  assign carry_o      = carry_q;

endmodule

// ===== rtl/strided_nd_copy_address_gen.sv =====
// strided n-dimensional copy address generator, top level
// usage: program elem_size, rank, bases and offsets through the cfg write port
// while idle, send one load item per axis (axis 0 outermost), a start item to arm
// the walk, then one step item per element. each step returns one item on out_o
// with the source and destination byte addresses, last on the final element,
// status for empty shapes or steps while not armed. load and start return nothing.
// a step result is written to the output register when the step is accepted.
// carries: a step that rolls axes over sends a carry outward one axis cell at a
// time through each cell's carry register; the final element, an empty shape and
// a step while not armed send no carry. a load passes through the two-stage stride
// multiplier before it reaches its axis cell; start arms the walk and clears cells.
// reset: not armed, elem_size 1, rank 1, counters and positions zero; axis
// descriptors hold nothing until loaded.
// stall: a result waits in the output register; in_i.ready stays low while it is
// not taken and while a carry or a load is in flight.
module strided_nd_copy_address_gen import sndc_pkg::*; #(
  parameter int MAX_RANK   = 4,
  parameter int ADDR_WIDTH = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  sndc_in_if.sink               in_i,
  sndc_out_if.source            out_o
);

  localparam int AW = ADDR_WIDTH;
  localparam int RW = $clog2(MAX_RANK + 1);

  logic [ESIZE_W-1:0]    elem_size_q;
  logic [RANK_W-1:0]     rank_q;
  logic [OUT_ADDR_W-1:0] src_base_q, dst_base_q;
  logic [OFF_W-1:0]      src_offset_q, dst_offset_q;

  logic [RW-1:0] used_rank;
  logic          in_fire, is_load, is_start, is_step;
  logic          armed_q, busy, ld_busy, go, all_wrap, any_zero;
  logic [AW-1:0] src_pos_q, dst_pos_q, src_delta, dst_delta;
  logic [AW-1:0] src_cur, dst_cur;
  logic [OFF_W+ESIZE_W-1:0] src_off_b, dst_off_b;

  logic                  out_vld_q, out_last_q;
  logic [OUT_ADDR_W-1:0] out_src_q, out_dst_q;
  logic [STAT_W-1:0]     out_stat_q;

  ld_ctl_t          ld_ctl;
  logic [EXT_W-1:0] ld_extent;
  logic [AW-1:0]    ld_src_stride, ld_dst_stride, ld_src_wrap, ld_dst_wrap;

  cell_stat_t    stat  [MAX_RANK];
  logic          carry [MAX_RANK];
  logic          tok   [MAX_RANK];
  logic [AW-1:0] sdel  [MAX_RANK];
  logic [AW-1:0] ddel  [MAX_RANK];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_size_q  <= ELEM_SIZE_RST;
      rank_q       <= RANK_RST;
      src_base_q   <= '0;
      dst_base_q   <= '0;
      src_offset_q <= '0;
      dst_offset_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ELEM_SIZE:  elem_size_q  <= cfg_wdata_i[ESIZE_W-1:0];
        REG_RANK:       rank_q       <= cfg_wdata_i[RANK_W-1:0];
        REG_SRC_BASE:   src_base_q   <= cfg_wdata_i[OUT_ADDR_W-1:0];
        REG_DST_BASE:   dst_base_q   <= cfg_wdata_i[OUT_ADDR_W-1:0];
        REG_SRC_OFFSET: src_offset_q <= cfg_wdata_i[OFF_W-1:0];
        REG_DST_OFFSET: dst_offset_q <= cfg_wdata_i[OFF_W-1:0];
        default: ;
      endcase
    end
  end

  assign used_rank = (4'(rank_q) > 4'(MAX_RANK)) ? RW'(MAX_RANK) : RW'(rank_q);

  assign in_fire  = in_i.valid & in_i.ready;
  assign is_load  = in_fire & (in_i.func == FUNC_LOAD);
  assign is_start = in_fire & (in_i.func == FUNC_START);
  assign is_step  = in_fire & (in_i.func == FUNC_STEP);

  sndc_scale #(.AW(AW)) u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .go_i         (is_load),
    .axis_i       (in_i.axis),
    .extent_i     (in_i.extent),
    .src_stride_i (in_i.src_stride),
    .dst_stride_i (in_i.dst_stride),
    .elem_size_i  (elem_size_q),
    .ctl_o        (ld_ctl),
    .busy_o       (ld_busy),
    .extent_o     (ld_extent),
    .src_stride_o (ld_src_stride),
    .dst_stride_o (ld_dst_stride),
    .src_wrap_o   (ld_src_wrap),
    .dst_wrap_o   (ld_dst_wrap)
  );

  // axis cells, innermost axis gets the step, carries move outward
  for (genvar a = 0; a < MAX_RANK; a++) begin : g_cell
    if (a == MAX_RANK - 1) begin : g_last
      assign tok[a] = go & (used_rank == RW'(a + 1));
    end else begin : g_mid
      assign tok[a] = (go & (used_rank == RW'(a + 1))) | carry[a+1];
    end

    sndc_cell #(.AW(AW)) u_cell (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .clr_i           (is_start),
      .ld_en_i         (ld_ctl.vld & (int'(ld_ctl.axis) == a)),
      .ld_extent_i     (ld_extent),
      .ld_src_stride_i (ld_src_stride),
      .ld_dst_stride_i (ld_dst_stride),
      .ld_src_wrap_i   (ld_src_wrap),
      .ld_dst_wrap_i   (ld_dst_wrap),
      .tok_i           (tok[a]),
      .stat_o          (stat[a]),
      .carry_o         (carry[a]),
      .src_delta_o     (sdel[a]),
      .dst_delta_o     (ddel[a])
    );
  end

  always_comb begin
    all_wrap  = 1'b1;
    any_zero  = 1'b0;
    busy      = ld_busy;
    src_delta = '0;
    dst_delta = '0;
    for (int a = 0; a < MAX_RANK; a++) begin
      if (RW'(a) < used_rank) begin
        all_wrap = all_wrap & stat[a].wrap;
        any_zero = any_zero | stat[a].empty;
      end
      busy      = busy | carry[a];
      src_delta = src_delta | sdel[a];
      dst_delta = dst_delta | ddel[a];
    end
  end

  assign go = is_step & armed_q & ~any_zero & (used_rank != '0) & ~all_wrap;

  assign src_off_b = src_offset_q * elem_size_q;
  assign dst_off_b = dst_offset_q * elem_size_q;
  assign src_cur   = AW'(src_base_q) + AW'(src_off_b) + src_pos_q;
  assign dst_cur   = AW'(dst_base_q) + AW'(dst_off_b) + dst_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q   <= 1'b0;
      src_pos_q <= '0;
      dst_pos_q <= '0;
    end else if (is_start) begin
      armed_q   <= 1'b1;
      src_pos_q <= '0;
      dst_pos_q <= '0;
    end else begin
      src_pos_q <= src_pos_q + src_delta;
      dst_pos_q <= dst_pos_q + dst_delta;
      if (is_step & armed_q & (any_zero | (used_rank == '0) | all_wrap)) begin
        armed_q <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (is_step) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_step) begin
      priority if (!armed_q) begin
        out_src_q  <= '0;
        out_dst_q  <= '0;
        out_last_q <= 1'b0;
        out_stat_q <= STAT_NOT_ARMED;
      end else if (any_zero) begin
        out_src_q  <= '0;
        out_dst_q  <= '0;
        out_last_q <= 1'b1;
        out_stat_q <= STAT_EMPTY;
      end else begin
        out_src_q  <= OUT_ADDR_W'(src_cur);
        out_dst_q  <= OUT_ADDR_W'(dst_cur);
        out_last_q <= (used_rank == '0) | all_wrap;
        out_stat_q <= STAT_ELEM;
      end
    end
  end

  assign in_i.ready     = ~busy & (~out_vld_q | out_o.ready);
  assign out_o.valid    = out_vld_q;
  assign out_o.src_addr = out_src_q;
  assign out_o.dst_addr = out_dst_q;
  assign out_o.last     = out_last_q;
  assign out_o.status   = out_stat_q;

endmodule
